>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the console writer.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define TMCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define TMCW_ASSERT_IMPL(label, pre, post, msg) \
    `TMCW_ASSERT(label, (pre) |-> (post), msg)

// Check that a condition implies a consequence in the next cycle
`define TMCW_ASSERT_NEXT(label, pre, post, msg) \
    `TMCW_ASSERT(label, (pre) |=> (post), msg)

`endif

>>> rtl/tmcw_pkg.sv
// Package for the text mode console writer: screen geometry, codes and
// the command word passed from the front end to the back end. No dependencies.
package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int ROW_W         = $clog2(ROWS);
    localparam int TAB_STEP      = 8;

    // Port field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int IDX_W   = 11;
    localparam int LOC_W   = 11;
    localparam int CELL_W  = 16;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_BKSP  = 3'd1,
        CMD_TAB   = 3'd2,
        CMD_CR    = 3'd3,
        CMD_LF    = 3'd4,
        CMD_NOP   = 3'd5,
        CMD_CLEAR = 3'd6,
        CMD_READ  = 3'd7
    } t_cmd_kind;

    // Command word held in the queue
    typedef struct packed {
        t_cmd_kind           kind;
        logic [CELL_W-1:0]   cell_word;
        logic [ADDR_W-1:0]   index;
        logic                index_ok;
    } t_cmd;

endpackage

>>> rtl/tmcw_ram.sv
// Generic simple dual port RAM: one write port, one read port with
// registered read data. No dependencies.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tmcw_front.sv
// Front end of the console writer: input handshake and classification of
// each item into a command word. Depends on tmcw_pkg.
module tmcw_front import tmcw_pkg::*; (
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [COLOR_W-1:0] i_back_color,
    input  logic [COLOR_W-1:0] i_fore_color,
    input  logic [IDX_W-1:0]   i_cell_index,
    input  logic               i_queue_full,
    input  logic               i_init_done,
    output logic               o_push,
    output t_cmd               o_cmd
);

    // Hold off items while the queue is full or the screen is being blanked after reset
    assign o_ready = !i_queue_full && i_init_done;
    assign o_push  = i_valid && o_ready;

    // Classify the word
    always_comb begin
        o_cmd.cell_word = {i_back_color, i_fore_color, i_char_code};
        o_cmd.index     = ADDR_W'(i_cell_index);
        o_cmd.index_ok  = ({1'b0, i_cell_index} < (IDX_W + 1)'(CELL_COUNT));
        o_cmd.kind      = CMD_NOP;
        case (i_op)
            OP_PUT: begin
                if (i_char_code == CH_BS) begin
                    o_cmd.kind = CMD_BKSP;
                end else if (i_char_code == CH_TAB) begin
                    o_cmd.kind = CMD_TAB;
                end else if (i_char_code == CH_CR) begin
                    o_cmd.kind = CMD_CR;
                end else if (i_char_code == CH_LF) begin
                    o_cmd.kind = CMD_LF;
                end else if (i_char_code >= CH_PRINT_LO && i_char_code <= CH_PRINT_HI) begin
                    o_cmd.kind = CMD_WRITE;
                end
            end
            OP_CLEAR: o_cmd.kind = CMD_CLEAR;
            OP_READ:  o_cmd.kind = CMD_READ;
            default:  o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

>>> rtl/tmcw_queue.sv
// Short command queue between front and back end of the console writer.
// Depends on tmcw_pkg.
module tmcw_queue import tmcw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_not_empty,
    output logic o_full,
    output t_cmd o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_head      = r_mem[r_rd_ptr];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tmcw_back.sv
// Back end of the console writer: cursor, screen memory sequencer for
// put, scroll, clear and read, and the result register. Depends on tmcw_pkg, tmcw_ram.
module tmcw_back import tmcw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_init_done,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LOC_W-1:0] o_cursor_pos,
    output logic [CELL_W-1:0] o_cell_value
);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_RDWAIT = 6'b000100,
        S_SCROLL = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE  = ADDR_W'(LAST_ROW_BASE);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [COL_W:0]    TAB_ADD    = (COL_W + 1)'(TAB_STEP);
    localparam logic [COL_W:0]    TAB_MASK   = ~((COL_W + 1)'(TAB_STEP - 1));
    localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

    t_state              r_state, n_state;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [ADDR_W-1:0]   r_ptr, n_ptr;
    logic [CELL_W-1:0]   r_val, n_val;
    logic                r_rd_ok, n_rd_ok;
    logic                r_wq_valid, n_wq_valid;
    logic                r_wq_copy, n_wq_copy;
    logic [ADDR_W-1:0]   r_wq_addr, n_wq_addr;
    logic [CELL_W-1:0]   r_wq_data, n_wq_data;
    logic                r_out_valid, n_out_valid;
    logic [LOC_W-1:0]    r_out_loc, n_out_loc;
    logic [CELL_W-1:0]   r_out_val, n_out_val;

    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;
    logic [CELL_W-1:0]   ram_wdata;
    logic [COL_W:0]      put_col;
    logic [ROW_W:0]      put_row;

    // Screen memory; a pending write takes its data from the read port on a copy
    assign ram_wdata = r_wq_copy ? ram_rdata : r_wq_data;

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wq_valid),
        .i_waddr (r_wq_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Linear cell address of the cursor
    assign cur_addr = ADDR_W'(r_row * COLUMNS) + ADDR_W'(r_col);

    // Cursor after a put, before any scroll
    always_comb begin
        put_col = {1'b0, r_col};
        put_row = {1'b0, r_row};
        case (i_cmd.kind)
            CMD_BKSP: begin
                if (r_col != '0) begin
                    put_col = put_col - 1'b1;
                end
            end
            CMD_TAB:   put_col = (put_col + TAB_ADD) & TAB_MASK;
            CMD_CR:    put_col = '0;
            CMD_LF: begin
                put_col = '0;
                put_row = put_row + 1'b1;
            end
            CMD_WRITE: put_col = put_col + 1'b1;
            default:   put_col = {1'b0, r_col};
        endcase
        // Wrap at the right edge
        if (put_col >= COL_LIMIT) begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_ptr       = r_ptr;
        n_val       = r_val;
        n_rd_ok     = r_rd_ok;
        n_wq_valid  = 1'b0;
        n_wq_copy   = 1'b0;
        n_wq_addr   = r_ptr;
        n_wq_data   = BLANK_CELL;
        n_out_valid = r_out_valid && !i_ready;
        n_out_loc   = r_out_loc;
        n_out_val   = r_out_val;
        ram_raddr   = i_cmd.index;
        o_pop       = 1'b0;
        case (r_state)
            // Blank the whole screen after reset
            S_INIT: begin
                n_wq_valid = 1'b1;
                n_ptr      = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end
            // Take the next command once the last write has landed
            S_IDLE: begin
                if (i_cmd_valid && !r_wq_valid) begin
                    o_pop = 1'b1;
                    n_val = '0;
                    case (i_cmd.kind)
                        CMD_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_ptr   = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_READ: begin
                            n_rd_ok = i_cmd.index_ok;
                            n_state = S_RDWAIT;
                        end
                        default: begin
                            if (i_cmd.kind == CMD_WRITE) begin
                                n_wq_valid = 1'b1;
                                n_wq_addr  = cur_addr;
                                n_wq_data  = i_cmd.cell_word;
                            end
                            n_col = put_col[COL_W-1:0];
                            n_row = put_row[ROW_W-1:0];
                            n_ptr = '0;
                            if (put_row >= ROW_LIMIT) begin
                                n_row   = LAST_ROW;
                                n_state = S_SCROLL;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            // Capture the cell read
            S_RDWAIT: begin
                n_val   = r_rd_ok ? ram_rdata : '0;
                n_state = S_EMIT;
            end
            // Copy each cell up one row, then blank the last row
            S_SCROLL: begin
                ram_raddr  = r_ptr + ROW_STRIDE;
                n_wq_valid = 1'b1;
                n_wq_copy  = (r_ptr < LAST_BASE);
                n_ptr      = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_EMIT;
                end
            end
            // Blank the whole screen
            S_CLEAR: begin
                n_wq_valid = 1'b1;
                n_ptr      = r_ptr + 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = S_EMIT;
                end
            end
            // Load the result register once it is free
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_loc   = LOC_W'(cur_addr);
                    n_out_val   = r_val;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_col       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_wq_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_ptr       <= n_ptr;
            r_wq_valid  <= n_wq_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_rd_ok   <= n_rd_ok;
        r_wq_copy <= n_wq_copy;
        r_wq_addr <= n_wq_addr;
        r_wq_data <= n_wq_data;
        r_out_loc <= n_out_loc;
        r_out_val <= n_out_val;
    end

    assign o_init_done  = (r_state != S_INIT);
    assign o_valid      = r_out_valid;
    assign o_cursor_pos = r_out_loc;
    assign o_cell_value = r_out_val;

endmodule

>>> rtl/text_mode_console_writer_core.sv
// Text mode console writer top level. A scroll or clear writes one screen cell
// per cycle through the single write port; a two-word queue takes items meanwhile.
// Reset (synchronous, active low) homes the cursor and runs a pass that blanks the
// screen; no item is accepted until it ends.
module text_mode_console_writer_core import tmcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [COLOR_W-1:0] i_back_color,
    input  logic [COLOR_W-1:0] i_fore_color,
    input  logic [IDX_W-1:0]   i_cell_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LOC_W-1:0]   o_cursor_pos,
    output logic [CELL_W-1:0]  o_cell_value
);

    logic q_full;
    logic q_not_empty;
    logic q_push;
    logic q_pop;
    logic init_done;
    t_cmd front_cmd;
    t_cmd head_cmd;

    tmcw_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_back_color (i_back_color),
        .i_fore_color (i_fore_color),
        .i_cell_index (i_cell_index),
        .i_queue_full (q_full),
        .i_init_done  (init_done),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    tmcw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_cmd       (front_cmd),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_full      (q_full),
        .o_head      (head_cmd)
    );

    tmcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_not_empty),
        .i_cmd        (head_cmd),
        .o_pop        (q_pop),
        .o_init_done  (init_done),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value)
    );

endmodule

>>> rtl/tmcw_checker.sv
// Port-level checker for the console writer top level, bound to it below.
// Depends on tmcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmcw_checker import tmcw_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [LOC_W-1:0]  o_cursor_pos,
    input logic [CELL_W-1:0] o_cell_value
);

    logic [3:0]              r_pend;
    logic [3:0]              n_pend;
    logic                    cursor_ok;
    logic                    cell_nonzero;
    logic                    cell_printable;
    logic                    out_stall;
    logic [LOC_W+CELL_W-1:0] res_word;

    // Count words accepted but not yet answered
    always_comb begin
        n_pend = r_pend;
        if (i_valid && o_ready && !(o_valid && i_ready)) begin
            n_pend = r_pend + 1'b1;
        end else if (!(i_valid && o_ready) && o_valid && i_ready) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // Terms of the checks below
    assign cursor_ok      = ({1'b0, o_cursor_pos} < (LOC_W + 1)'(CELL_COUNT));
    assign cell_nonzero   = o_valid && (o_cell_value != '0);
    assign cell_printable = (o_cell_value[7] == 1'b0) && (o_cell_value[6:0] >= 7'h20);
    assign out_stall      = o_valid && !i_ready;
    assign res_word       = {o_cursor_pos, o_cell_value};

    // A result only ever answers an accepted word
    `TMCW_ASSERT_IMPL(a_no_spurious_result, o_valid, r_pend != 4'd0, "result without an item")

    // The cursor stays on the screen
    `TMCW_ASSERT_IMPL(a_cursor_on_screen, o_valid, cursor_ok, "cursor off screen")

    // Any non-zero cell holds a printable character
    `TMCW_ASSERT_IMPL(a_cell_printable, cell_nonzero, cell_printable, "non-printable cell")

    // A stalled result holds
    `TMCW_ASSERT_NEXT(a_result_holds, out_stall, o_valid && $stable(res_word), "result moved")

endmodule

bind text_mode_console_writer_core tmcw_checker u_checker (.*);

>>> bench/tb_text_mode_console_writer_core.sv
// Self-checking bench for text_mode_console_writer_core: a shadow of the screen
// and cursor predicts each result word, checked field by field in arrival order.
// Depends on tmcw_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_text_mode_console_writer_core;
    import tmcw_pkg::*;

    // Opcode the core leaves unused, and stimulus ranges of ignored codes
    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam logic [CHAR_W-1:0] CH_CTRL_LO = 8'h00;
    localparam logic [CHAR_W-1:0] CH_CTRL_HI = 8'h1F;
    localparam logic [CHAR_W-1:0] CH_HIGH_LO = 8'h80;
    localparam logic [CHAR_W-1:0] CH_HIGH_HI = 8'hFF;

    localparam int RANDOM_WORDS = 240;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 2100;
    localparam int TIMEOUT_NS   = 40_000_000;

    typedef struct packed {
        logic [LOC_W-1:0]  loc;
        logic [CELL_W-1:0] value;
        longint unsigned   noted_at;
    } t_console_result;

    // Shadow of the screen and cursor, plus the results still owed by the core
    class console_shadow;
        logic [CELL_W-1:0] screen [CELL_COUNT];
        int unsigned       cur_col;
        int unsigned       cur_row;
        t_console_result   owed_q [$];
        int unsigned       failures;

        function new();
            blank_screen();
            cur_col  = 0;
            cur_row  = 0;
            failures = 0;
        endfunction

        function void blank_screen();
            foreach (screen[i]) screen[i] = BLANK_CELL;
        endfunction

        function int unsigned location();
            return cur_row * COLUMNS + cur_col;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted word to the shadow and queue the result it owes
        function void note_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                                input logic [COLOR_W-1:0] back, input logic [COLOR_W-1:0] fore,
                                input logic [IDX_W-1:0] idx);
            t_console_result owed;
            owed.value = '0;
            case (op)
                OP_PUT: begin
                    if (code == CH_BS) begin
                        if (cur_col != 0) cur_col--;
                    end else if (code == CH_TAB) begin
                        cur_col = (cur_col + TAB_STEP) / TAB_STEP * TAB_STEP;
                    end else if (code == CH_CR) begin
                        cur_col = 0;
                    end else if (code == CH_LF) begin
                        cur_col = 0;
                        cur_row++;
                    end else if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
                        if (location() < CELL_COUNT) screen[location()] = {back, fore, code};
                        cur_col++;
                    end
                    // Wrap at the right edge, then scroll off the bottom
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    if (cur_row >= ROWS) begin
                        for (int i = 0; i < LAST_ROW_BASE; i++) screen[i] = screen[i + COLUMNS];
                        for (int i = LAST_ROW_BASE; i < CELL_COUNT; i++) screen[i] = BLANK_CELL;
                        cur_row = ROWS - 1;
                    end
                end
                OP_CLEAR: begin
                    blank_screen();
                    cur_col = 0;
                    cur_row = 0;
                end
                OP_READ: begin
                    if (idx < CELL_COUNT) owed.value = screen[idx];
                end
                default: ;
            endcase
            owed.loc      = LOC_W'(location());
            owed.noted_at = $time;
            owed_q.push_back(owed);
        endfunction

        // Compare one result word with the oldest owed result
        function void check_word(input logic [LOC_W-1:0] loc, input logic [CELL_W-1:0] cell_val);
            t_console_result owed;
            // A word accepted on this very edge cannot have its result yet
            if (owed_q.size() == 0 || owed_q[0].noted_at == $time) begin
                $error("result with nothing owed: cursor_pos %0d, cell_value 0x%04h",
                       loc, cell_val);
                failures++;
                return;
            end
            owed = owed_q.pop_front();
            if (loc !== owed.loc) begin
                $error("cursor_pos: expected %0d, got %0d", owed.loc, loc);
                failures++;
            end
            if (cell_val !== owed.value) begin
                $error("cell_value: expected 0x%04h, got 0x%04h", owed.value, cell_val);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [OP_W-1:0]    i_op         = OP_PUT;
    logic [CHAR_W-1:0]  i_char_code  = '0;
    logic [COLOR_W-1:0] i_back_color = '0;
    logic [COLOR_W-1:0] i_fore_color = '0;
    logic [IDX_W-1:0]   i_cell_index = '0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [LOC_W-1:0]   o_cursor_pos;
    logic [CELL_W-1:0]  o_cell_value;

    console_shadow shadow = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_taken   = 0;
    int hold_left     = 0;
    int words_sent    = 0;

    text_mode_console_writer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_back_color (i_back_color),
        .i_fore_color (i_fore_color),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value)
    );

    always #5 i_clk = ~i_clk;

    // Result side: stall at random, or hold off for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_requests != holds_taken) begin
            holds_taken = holds_taken + 1;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready  <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Check every result word as it leaves
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) shadow.check_word(o_cursor_pos, o_cell_value);
    end

    // Offer one word after a random gap, hold it until taken, then note it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] code,
                             input logic [COLOR_W-1:0] back, input logic [COLOR_W-1:0] fore,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_char_code  <= code;
        i_back_color <= back;
        i_fore_color <= fore;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_word(op, code, back, fore, idx);
        words_sent++;
    endtask

    task automatic put_code(input logic [CHAR_W-1:0] code);
        send_word(OP_PUT, code, COLOR_W'($urandom), COLOR_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_word(OP_READ, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), idx);
    endtask

    function automatic logic [CHAR_W-1:0] printable();
        return CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    endfunction

    // One burst of console traffic: mostly text lines, with reads and odd codes
    task automatic random_burst();
        int          kind;
        int          n;
        int          k;
        int unsigned loc;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            // Short line with the odd backspace or tab, usually ended
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) put_code($urandom_range(0, 1) ? CH_BS : CH_TAB);
                else put_code(printable());
            end
            k = $urandom_range(0, 99);
            if (k < 75) put_code(CH_LF);
            else if (k < 90) put_code(CH_CR);
        end else if (kind < 48) begin
            // Long line that can wrap past the right edge
            n = $urandom_range(70, 100);
            repeat (n) put_code(printable());
        end else if (kind < 63) begin
            repeat ($urandom_range(1, 5)) put_code(CH_LF);
        end else if (kind < 73) begin
            repeat ($urandom_range(1, 12)) put_code(CH_TAB);
        end else if (kind < 88) begin
            // Reads, mostly just behind the cursor where text was written
            repeat ($urandom_range(1, 3)) begin
                loc = shadow.location();
                k   = $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) read_cell(IDX_W'($urandom));
                else if (loc >= k) read_cell(IDX_W'(loc - k));
                else read_cell(IDX_W'($urandom_range(0, CELL_COUNT - 1)));
            end
        end else if (kind < 91) begin
            send_word(OP_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                      IDX_W'($urandom));
        end else begin
            k = $urandom_range(0, 3);
            case (k)
                0: send_word(OP_UNUSED, CHAR_W'($urandom), COLOR_W'($urandom),
                             COLOR_W'($urandom), IDX_W'($urandom));
                1: put_code(CHAR_W'($urandom_range(CH_CTRL_LO, CH_CTRL_HI)));
                2: put_code(CHAR_W'($urandom_range(CH_HIGH_LO, CH_HIGH_HI)));
                default: begin
                    put_code(CH_CR);
                    put_code(CH_BS);
                end
            endcase
        end
    endtask

    initial begin
        int idle_by_phase  [4];
        int stall_by_phase [4];
        int target;

        idle_by_phase  = '{0, 53, 0, 7};
        stall_by_phase = '{0, 0, 53, 7};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: read extremes, field extremes, every control code, clear
        read_cell('0);
        read_cell(IDX_W'(CELL_COUNT - 1));
        read_cell(IDX_W'(CELL_COUNT));
        read_cell('1);
        send_word(OP_PUT, 8'h41, '0, '0, '0);
        send_word(OP_PUT, CH_PRINT_HI, '1, '1, '1);
        send_word(OP_PUT, CH_PRINT_LO, 4'h5, 4'hA, '0);
        put_code(CH_CTRL_LO);
        put_code(CH_CTRL_HI);
        put_code(CH_HIGH_LO);
        put_code(CH_HIGH_HI);
        put_code(CH_BS);
        put_code(CH_CR);
        put_code(CH_BS);
        put_code(CH_TAB);
        put_code(CH_LF);
        send_word(OP_UNUSED, '1, '1, '1, '1);
        read_cell('0);
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(2));
        send_word(OP_CLEAR, '1, '1, '1, '1);
        read_cell('0);

        // Hold off the result side while words keep coming, so the core backs up
        hold_requests <= hold_requests + 1;
        repeat (16) put_code(printable());

        // Random traffic across the idling phases
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_by_phase[p];
            stall_pct    <= stall_by_phase[p];
            target        = words_sent + RANDOM_WORDS / 4;
            while (words_sent < target) random_burst();
        end

        // Drain: wait for every owed result, then watch for strays
        i_valid   <= 1'b0;
        stall_pct <= 0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.failures == 0) begin
            $display("tb_text_mode_console_writer_core: PASS");
        end else begin
            $display("tb_text_mode_console_writer_core: FAIL");
        end
        $finish;
    end

    // Give up if the core hangs
    initial begin
        #(TIMEOUT_NS);
        $display("tb_text_mode_console_writer_core: FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/tmcw_pkg.sv
rtl/tmcw_ram.sv
rtl/tmcw_front.sv
rtl/tmcw_queue.sv
rtl/tmcw_back.sv
rtl/text_mode_console_writer_core.sv
rtl/tmcw_checker.sv
bench/tb_text_mode_console_writer_core.sv
